FILE: hdl/grr_pkg.sv
// Shared types, constants and helpers for the GSI redirection router.
// Used by every module in hdl/; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package grr_pkg;

  localparam int CONTROLLERS = 3;
  localparam int MAX_ENTRIES = 32;
  localparam int TABLE_DEPTH = CONTROLLERS * MAX_ENTRIES;

  localparam int GSI_W   = 32;
  localparam int VEC_W   = 8;
  localparam int DEST_W  = 8;
  localparam int CNT_W   = 6;
  localparam int ACT_W   = 2;
  localparam int CTRL_W  = 2;
  localparam int ENTRY_W = 5;
  localparam int SLOT_W  = $clog2(TABLE_DEPTH);
  localparam int LOW_W   = 17;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [VEC_W-1:0] VEC_MIN     = 8'd32;
  localparam logic [VEC_W-1:0] RESET_VEC   = 8'hFF;
  localparam logic [CNT_W-1:0] ENTRY_LIMIT = CNT_W'(MAX_ENTRIES);
  localparam logic [ACT_W-1:0] CTRL_LIMIT  = ACT_W'(CONTROLLERS);

  typedef enum logic {
    OP_ROUTE = 1'b0,
    OP_MASK  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE       = 2'd0,
    ST_BAD_VECTOR = 2'd1,
    ST_NO_CTRL    = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ACTIVE  = 3'd0,
    CFG_BASE_0  = 3'd1,
    CFG_BASE_1  = 3'd2,
    CFG_BASE_2  = 3'd3,
    CFG_COUNT_0 = 3'd4,
    CFG_COUNT_1 = 3'd5,
    CFG_COUNT_2 = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [ACT_W-1:0]                   active;
    logic [CONTROLLERS-1:0][GSI_W-1:0]  win_base;
    logic [CONTROLLERS-1:0][CNT_W-1:0]  entry_count;
  } cfg_t;

  typedef struct packed {
    logic               hit;
    logic [CTRL_W-1:0]  ctrl;
    logic [ENTRY_W-1:0] entry;
    logic [SLOT_W-1:0]  slot;
  } lookup_t;

  // One redirection entry as stored.
  typedef struct packed {
    logic              mask;
    logic              trig;
    logic              pol;
    logic [VEC_W-1:0]  vector;
    logic [DEST_W-1:0] dest;
  } entry_t;

  typedef struct packed {
    op_e               op;
    logic [GSI_W-1:0]  gsi;
    logic [VEC_W-1:0]  vector;
    logic [DEST_W-1:0] dest;
    logic              lvl;
    logic              alow;
    logic              msk;
  } item_t;

  localparam entry_t RESET_ENTRY = '{mask: 1'b1, trig: 1'b0, pol: 1'b0,
                                     vector: RESET_VEC, dest: '0};

  // Low word layout: mask 16, trigger 15, polarity 13, vector 7:0.
  function automatic logic [LOW_W-1:0] low_word(entry_t e);
    low_word = {e.mask, e.trig, 1'b0, e.pol, 5'b0, e.vector};
  endfunction

endpackage

`default_nettype wire

FILE: hdl/grr_cfg_regs.sv
// Configuration register file: controller count, window bases and sizes.
// Depends on grr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module grr_cfg_regs (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [grr_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [grr_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output grr_pkg::cfg_t                       cfg_o
);

  grr_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (grr_pkg::cfg_idx_e'(cfg_index_i))
        grr_pkg::CFG_ACTIVE: begin
          cfg_q.active <= cfg_data_i[grr_pkg::ACT_W-1:0];
        end
        grr_pkg::CFG_BASE_0: begin
          cfg_q.win_base[0] <= cfg_data_i[grr_pkg::GSI_W-1:0];
        end
        grr_pkg::CFG_BASE_1: begin
          cfg_q.win_base[1] <= cfg_data_i[grr_pkg::GSI_W-1:0];
        end
        grr_pkg::CFG_BASE_2: begin
          cfg_q.win_base[2] <= cfg_data_i[grr_pkg::GSI_W-1:0];
        end
        grr_pkg::CFG_COUNT_0: begin
          cfg_q.entry_count[0] <= cfg_data_i[grr_pkg::CNT_W-1:0];
        end
        grr_pkg::CFG_COUNT_1: begin
          cfg_q.entry_count[1] <= cfg_data_i[grr_pkg::CNT_W-1:0];
        end
        grr_pkg::CFG_COUNT_2: begin
          cfg_q.entry_count[2] <= cfg_data_i[grr_pkg::CNT_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

FILE: hdl/grr_lookup.sv
// Window match: finds the first active controller whose window holds the GSI.
// Depends on grr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module grr_lookup (
  input  wire grr_pkg::cfg_t                 cfg_i,
  input  wire logic [grr_pkg::GSI_W-1:0]     gsi_i,
  output grr_pkg::lookup_t                   res_o
);

  logic [grr_pkg::ACT_W-1:0]                          act_cap;
  logic [grr_pkg::CONTROLLERS-1:0]                    hit;
  logic [grr_pkg::CONTROLLERS-1:0][grr_pkg::GSI_W:0]  diff;
  logic [grr_pkg::CONTROLLERS-1:0][grr_pkg::CNT_W-1:0] cnt;

  assign act_cap = (cfg_i.active > grr_pkg::CTRL_LIMIT) ? grr_pkg::CTRL_LIMIT : cfg_i.active;

  always_comb begin
    for (int c = 0; c < grr_pkg::CONTROLLERS; c++) begin
      cnt[c]  = (cfg_i.entry_count[c] > grr_pkg::ENTRY_LIMIT) ? grr_pkg::ENTRY_LIMIT
                                                              : cfg_i.entry_count[c];
      // borrow bit set means gsi below base
      diff[c] = {1'b0, gsi_i} - {1'b0, cfg_i.win_base[c]};
      hit[c]  = (grr_pkg::ACT_W'(c) < act_cap) && !diff[c][grr_pkg::GSI_W] &&
                (diff[c][grr_pkg::GSI_W-1:0] < grr_pkg::GSI_W'(cnt[c]));
    end
  end

  // Priority pick, lowest index wins.
  always_comb begin
    res_o = '0;
    for (int c = grr_pkg::CONTROLLERS - 1; c >= 0; c--) begin
      if (hit[c]) begin
        res_o.hit   = 1'b1;
        res_o.ctrl  = grr_pkg::CTRL_W'(c);
        res_o.entry = diff[c][grr_pkg::ENTRY_W-1:0];
      end
    end
    res_o.slot = grr_pkg::SLOT_W'(res_o.ctrl) * grr_pkg::SLOT_W'(grr_pkg::MAX_ENTRIES) +
                 grr_pkg::SLOT_W'(res_o.entry);
  end

endmodule

`default_nettype wire

FILE: hdl/grr_table.sv
// Redirection table: one write port, one registered read port, write-first
// bypass. Per-entry valid flops make unwritten entries read as reset value.
// Depends on grr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module grr_table (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         rd_en_i,
  input  wire logic [grr_pkg::SLOT_W-1:0]   rd_addr_i,
  output grr_pkg::entry_t                   rd_data_o,
  input  wire logic                         wr_en_i,
  input  wire logic [grr_pkg::SLOT_W-1:0]   wr_addr_i,
  input  wire grr_pkg::entry_t              wr_data_i
);

  grr_pkg::entry_t                   mem_q [grr_pkg::TABLE_DEPTH];
  logic [grr_pkg::TABLE_DEPTH-1:0]   valid_q;
  grr_pkg::entry_t                   rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_en_i) begin
      valid_q[wr_addr_i] <= 1'b1;
    end
  end

  // same-cycle write to the read slot returns the new data
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      if (wr_en_i && (wr_addr_i == rd_addr_i)) begin
        rd_q <= wr_data_i;
      end else if (valid_q[rd_addr_i]) begin
        rd_q <= mem_q[rd_addr_i];
      end else begin
        rd_q <= grr_pkg::RESET_ENTRY;
      end
    end
  end

  assign rd_data_o = rd_q;

endmodule

`default_nettype wire

FILE: hdl/gsi_redirection_router.sv
// GSI redirection router, top level.
// Input channel (in_valid_i/in_ready_o) takes one request beat: operation,
// GSI and the route fields. Output channel (out_valid_o/out_ready_i) gives
// one result beat per request, in order: status, controller, entry, the
// entry's low word and destination after the operation.
// Configuration is a plain write port (cfg_we_i, cfg_index_i, cfg_data_i); the user
// must write it only while no request is in flight, the block does not enforce it.
// Pipeline: input register, lookup and table read, table write and result
// register. Throughput is one beat per cycle while the receiver does not
// stall, also for back-to-back mask requests to the same entry, since the
// table read port forwards the write in progress. When the receiver stalls
// the result register holds and the stall moves back stage by stage; the
// input side keeps taking beats until all three stages are full.
// Reset empties the pipeline, clears the configuration registers to zero and marks every
// table entry as masked with vector 0xFF and destination 0 at once.
// Depends on grr_pkg, grr_cfg_regs, grr_lookup, grr_table.
`timescale 1ns / 1ps
`default_nettype none

module gsi_redirection_router (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [grr_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [grr_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic                            operation_i,
  input  wire logic [grr_pkg::GSI_W-1:0]       gsi_i,
  input  wire logic [grr_pkg::VEC_W-1:0]       vector_i,
  input  wire logic [grr_pkg::DEST_W-1:0]      destination_i,
  input  wire logic                            level_trigger_i,
  input  wire logic                            active_low_i,
  input  wire logic                            masked_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic [1:0]                           status_o,
  output logic [grr_pkg::CTRL_W-1:0]           controller_index_o,
  output logic [grr_pkg::ENTRY_W-1:0]          entry_index_o,
  output logic [grr_pkg::LOW_W-1:0]            redirection_low_o,
  output logic [grr_pkg::DEST_W-1:0]           destination_out_o
);

  grr_pkg::cfg_t    cfg;
  grr_pkg::lookup_t lk;

  logic             s1_valid_q, s2_valid_q, out_valid_q;
  logic             s1_adv, s2_adv;
  grr_pkg::item_t   s1_item_q, s2_item_q;
  grr_pkg::status_e s1_status, s2_status_q;
  grr_pkg::lookup_t s2_lk_q;
  grr_pkg::entry_t  rd_data, new_entry;
  logic             wr_en;

  grr_pkg::status_e                   out_status_q;
  logic [grr_pkg::CTRL_W-1:0]         out_ctrl_q;
  logic [grr_pkg::ENTRY_W-1:0]        out_entry_q;
  logic [grr_pkg::LOW_W-1:0]          out_low_q;
  logic [grr_pkg::DEST_W-1:0]         out_dest_q;

  grr_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Handshake chain
  assign s2_adv     = s2_valid_q && (!out_valid_q || out_ready_i);
  assign s1_adv     = s1_valid_q && (!s2_valid_q || s2_adv);
  assign in_ready_o = !s1_valid_q || s1_adv;

  // Stage 1: input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_item_q <= '{op: grr_pkg::op_e'(operation_i), gsi: gsi_i, vector: vector_i,
                     dest: destination_i, lvl: level_trigger_i, alow: active_low_i,
                     msk: masked_i};
    end
  end

  grr_lookup u_lookup (
    .cfg_i (cfg),
    .gsi_i (s1_item_q.gsi),
    .res_o (lk)
  );

  // vector check comes before the lookup
  always_comb begin
    if (s1_item_q.op == grr_pkg::OP_ROUTE && s1_item_q.vector < grr_pkg::VEC_MIN) begin
      s1_status = grr_pkg::ST_BAD_VECTOR;
    end else if (!lk.hit) begin
      s1_status = grr_pkg::ST_NO_CTRL;
    end else begin
      s1_status = grr_pkg::ST_DONE;
    end
  end

  grr_table u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (s1_adv),
    .rd_addr_i (lk.slot),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (s2_lk_q.slot),
    .wr_data_i (new_entry)
  );

  // Stage 2: build the new entry (route replaces, mask merges with stored entry) and write back
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (!s2_valid_q || s2_adv) begin
      s2_valid_q <= s1_adv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      s2_item_q   <= s1_item_q;
      s2_status_q <= s1_status;
      s2_lk_q     <= lk;
    end
  end

  always_comb begin
    if (s2_item_q.op == grr_pkg::OP_ROUTE) begin
      new_entry = '{mask: s2_item_q.msk, trig: s2_item_q.lvl, pol: s2_item_q.alow,
                    vector: s2_item_q.vector, dest: s2_item_q.dest};
    end else begin
      new_entry      = rd_data;
      new_entry.mask = s2_item_q.msk;
    end
  end

  assign wr_en = s2_adv && (s2_status_q == grr_pkg::ST_DONE);

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || out_ready_i) begin
      out_valid_q <= s2_adv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_adv) begin
      out_status_q <= s2_status_q;
      if (s2_status_q == grr_pkg::ST_DONE) begin
        out_ctrl_q  <= s2_lk_q.ctrl;
        out_entry_q <= s2_lk_q.entry;
        out_low_q   <= grr_pkg::low_word(new_entry);
        out_dest_q  <= new_entry.dest;
      end else begin
        out_ctrl_q  <= '0;
        out_entry_q <= '0;
        out_low_q   <= '0;
        out_dest_q  <= '0;
      end
    end
  end

  assign out_valid_o        = out_valid_q;
  assign status_o           = out_status_q;
  assign controller_index_o = out_ctrl_q;
  assign entry_index_o      = out_entry_q;
  assign redirection_low_o  = out_low_q;
  assign destination_out_o  = out_dest_q;

endmodule

`default_nettype wire
